### rtl/atc_pkg.sv
// Package for the text console: geometry constants, payload structs, command codes,
// the colour map and the controller/datapath command and status structs.
// Used by every module under rtl except atc_ram.
package atc_pkg;

	localparam int SCREEN_COLUMNS = 80;
	localparam int SCREEN_ROWS = 25;
	localparam int TAB_STOP = 8;
	localparam int PARAM_SLOTS = 4;
	localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int SLOT_W = (PARAM_SLOTS > 1) ? $clog2(PARAM_SLOTS) : 1;
	localparam int COL_W = 7;
	localparam int ROW_W = 5;

	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_M = 8'h6D;
	localparam logic [7:0] ATTR_RESET = 8'h0F;

	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_ESC = 2'd1;
	localparam logic [1:0] MODE_CSI = 2'd2;

	typedef enum logic [1:0] {
		CMD_PUT = 2'd0,
		CMD_READ = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_COLOUR = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] char_code;
		logic [10:0] cell_index;
		logic [3:0] fore;
		logic [3:0] back;
	} in_item_t;

	typedef struct packed {
		logic [6:0] cursor_col;
		logic [4:0] cursor_row;
		logic [7:0] read_char;
		logic [7:0] read_attr;
		logic [7:0] text_attr;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_CHAR,
		OP_SCROLL_INIT,
		OP_CLEAR_INIT,
		OP_SGR_INIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic walk_step;
		logic sgr_step;
		logic read_cap;
	} dp_cmd_t;

	typedef struct packed {
		logic scroll_need;
		logic walk_done;
		logic sgr_done;
		logic sgr_final;
	} dp_stat_t;

	function automatic logic [2:0] colour_map(input logic [2:0] c);
		logic [2:0] r;
		r = {c[0], c[1], c[2]};
		return r;
	endfunction

endpackage

### rtl/ansi_text_console_core.sv
// Top level of the text console: controller plus datapath.
// Depends on atc_pkg, atc_ctrl and atc_datapath.
//
// One item is taken at a time. After reset the block clears the screen RAM to zero,
// with the input stalled. An SGR final applies its parameters one per cycle. A clear,
// and a character that scrolls, walk the screen one cell per cycle over the single
// RAM port pair.
module ansi_text_console_core
	import atc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output out_item_t out_item
);
	dp_cmd_t cmd;
	dp_stat_t stat;

	atc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_command(in_item.command),
		.in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
		.cmd(cmd), .stat(stat)
	);

	atc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .cmd(cmd), .stat(stat),
		.result(out_item)
	);
endmodule

### rtl/atc_ram.sv
// Generic RAM with one write port and one read port, with registered read.
// Depends on nothing.
module atc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/atc_datapath.sv
// Datapath of the console: cursor, attribute, parser registers, screen RAM and walk counter.
// Depends on atc_pkg and atc_ram.
module atc_datapath
	import atc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input in_item_t in_item,
	input dp_cmd_t cmd,
	output dp_stat_t stat,
	output out_item_t result
);
	in_item_t item_q;
	logic [1:0] mode_q;
	logic [7:0] params_q [PARAM_SLOTS];
	logic [SLOT_W-1:0] slot_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [7:0] attr_q;
	logic [7:0] rchar_q, rattr_q;
	logic scroll_q, clear_walk_q;
	logic [ADDR_W-1:0] walk_q;
	logic [SLOT_W-1:0] sgr_i_q;
	logic init_q;
	logic boot_q;

	logic we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [15:0] wdata, rdata;

	atc_ram #(.WIDTH(16), .DEPTH(CELL_COUNT)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [7:0] ch;
	logic [ADDR_W-1:0] cur_addr;
	logic [COL_W:0] ncol;
	logic [ROW_W:0] nrow;
	logic cwe;
	logic [7:0] cchar;
	logic [ROW_W-1:0] brow;
	logic [COL_W-1:0] bcol;
	logic [7:0] p;
	logic [7:0] a;
	logic [11:0] prod;

	assign ch = item_q.char_code;

	always_comb begin
		brow = row_q;
		bcol = col_q;
		ncol = {1'b0, col_q};
		nrow = {1'b0, row_q};
		cwe = 1'b0;
		cchar = ch;
		if (ch == CH_LF) begin
			ncol = '0;
			nrow = nrow + 1'b1;
		end else if (ch == CH_CR) begin
			ncol = '0;
		end else if (ch == CH_TAB) begin
			ncol = {1'b0, col_q} - ({1'b0, col_q} % (COL_W+1)'(TAB_STOP))
				+ (COL_W+1)'(TAB_STOP);
		end else if (ch == CH_BS) begin
			if (col_q != '0) begin
				bcol = col_q - 1'b1;
			end else if (row_q != '0) begin
				brow = row_q - 1'b1;
				bcol = COL_W'(SCREEN_COLUMNS - 1);
			end
			ncol = {1'b0, bcol};
			nrow = {1'b0, brow};
			cwe = 1'b1;
			cchar = CH_SPACE;
		end else if (ch != CH_NUL) begin
			cwe = 1'b1;
			ncol = ncol + 1'b1;
		end
		if (ncol >= (COL_W+1)'(SCREEN_COLUMNS)) begin
			ncol = '0;
			nrow = nrow + 1'b1;
		end
		cur_addr = ADDR_W'(brow * SCREEN_COLUMNS) + ADDR_W'(bcol);
	end

	logic normal_char;
	assign normal_char = (mode_q == MODE_NORMAL) && (ch != CH_ESC);

	always_comb begin
		p = params_q[sgr_i_q];
		a = attr_q;
		if (p == 8'd0) a = ATTR_RESET;
		else if (p == 8'd1) a = attr_q | 8'h08;
		else if (p >= 8'd30 && p <= 8'd37)
			a = {attr_q[7:4], 1'b0, colour_map(3'(p - 8'd30))};
		else if (p >= 8'd40 && p <= 8'd47)
			a = {1'b0, colour_map(3'(p - 8'd40)), attr_q[3:0]};
		else if (p >= 8'd90 && p <= 8'd97)
			a = {attr_q[7:4], 1'b1, colour_map(3'(p - 8'd90))};
		else if (p >= 8'd100 && p <= 8'd107)
			a = {1'b1, colour_map(3'(p - 8'd100)), attr_q[3:0]};
	end

	assign prod = {4'd0, params_q[slot_q]} * 12'd10 + 12'(ch - 8'h30);

	always_comb begin
		we = 1'b0;
		waddr = cur_addr;
		wdata = {attr_q, cchar};
		raddr = item_q.cell_index[ADDR_W-1:0];
		if (cmd.op == OP_CHAR && normal_char) begin
			we = cwe;
		end
		if (cmd.walk_step) begin
			if (clear_walk_q) begin
				we = 1'b1;
				waddr = walk_q;
				wdata = boot_q ? 16'd0 : {item_q.back, 4'd0, CH_SPACE};
			end else begin
				raddr = ADDR_W'(walk_q + ADDR_W'(SCREEN_COLUMNS));
				we = !init_q;
				waddr = ADDR_W'(walk_q - 1'b1);
				wdata = (walk_q > ADDR_W'(CELL_COUNT - SCREEN_COLUMNS))
					? {attr_q, CH_SPACE} : rdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			for (int i = 0; i < PARAM_SLOTS; i++) params_q[i] <= '0;
			slot_q <= '0;
			col_q <= '0;
			row_q <= '0;
			attr_q <= ATTR_RESET;
			scroll_q <= 1'b0;
			clear_walk_q <= 1'b1;
			walk_q <= '0;
			sgr_i_q <= '0;
			init_q <= 1'b0;
			boot_q <= 1'b1;
		end else begin
			case (cmd.op)
				OP_CHAR: begin
					scroll_q <= 1'b0;
					if (mode_q == MODE_ESC) begin
						if (ch == CH_LBRACKET) begin
							mode_q <= MODE_CSI;
							for (int i = 0; i < PARAM_SLOTS; i++) params_q[i] <= '0;
							slot_q <= '0;
						end else begin
							mode_q <= MODE_NORMAL;
						end
					end else if (mode_q != MODE_NORMAL) begin
						if (ch >= 8'h30 && ch <= 8'h39) begin
							params_q[slot_q] <= (prod > 12'd255) ? 8'd255 : prod[7:0];
						end else if (ch == CH_SEMI) begin
							if (32'(slot_q) < PARAM_SLOTS - 1) slot_q <= slot_q + 1'b1;
						end else if (ch != CH_M) begin
							mode_q <= MODE_NORMAL;
						end
					end else if (ch == CH_ESC) begin
						mode_q <= MODE_ESC;
					end else begin
						col_q <= ncol[COL_W-1:0];
						if (nrow >= (ROW_W+1)'(SCREEN_ROWS)) begin
							row_q <= ROW_W'(SCREEN_ROWS - 1);
							scroll_q <= 1'b1;
						end else begin
							row_q <= nrow[ROW_W-1:0];
						end
					end
				end
				OP_SCROLL_INIT: begin
					clear_walk_q <= 1'b0;
					walk_q <= '0;
					init_q <= 1'b1;
				end
				OP_CLEAR_INIT: begin
					clear_walk_q <= 1'b1;
					walk_q <= '0;
					col_q <= '0;
					row_q <= '0;
				end
				OP_SGR_INIT: begin
					sgr_i_q <= '0;
				end
				OP_LOAD: begin
					boot_q <= 1'b0;
					if (in_item.command == CMD_COLOUR)
						attr_q <= {in_item.back, in_item.fore};
				end
				default: ;
			endcase
			if (cmd.walk_step) begin
				walk_q <= walk_q + 1'b1;
				init_q <= 1'b0;
				scroll_q <= 1'b0;
			end
			if (cmd.sgr_step) begin
				attr_q <= a;
				sgr_i_q <= sgr_i_q + 1'b1;
				if (sgr_i_q == slot_q) mode_q <= MODE_NORMAL;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) item_q <= in_item;
		if (cmd.op == OP_LOAD) begin
			rchar_q <= '0;
			rattr_q <= '0;
		end
		if (cmd.read_cap && 32'(item_q.cell_index) < CELL_COUNT) begin
			rchar_q <= rdata[7:0];
			rattr_q <= rdata[15:8];
		end
	end

	assign stat.scroll_need = scroll_q;
	assign stat.walk_done = clear_walk_q ? (walk_q == ADDR_W'(CELL_COUNT - 1))
		: (walk_q == ADDR_W'(CELL_COUNT));
	assign stat.sgr_done = (sgr_i_q == slot_q);
	assign stat.sgr_final = (mode_q == MODE_CSI) && (ch == CH_M);

	assign result.cursor_col = col_q;
	assign result.cursor_row = row_q;
	assign result.read_char = rchar_q;
	assign result.read_attr = rattr_q;
	assign result.text_attr = attr_q;
endmodule

### rtl/atc_ctrl.sv
// Controller of the console: sequences each item through the datapath.
// Depends on atc_pkg.
module atc_ctrl
	import atc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [1:0] in_command,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	output dp_cmd_t cmd,
	input dp_stat_t stat
);
	typedef enum logic [3:0] {
		S_BOOT, S_IDLE, S_DISPATCH, S_CHAR, S_CHK, S_WALK, S_SGR, S_READ, S_CAP, S_OUT,
		S_SCRL
	} state_t;

	state_t state_q;
	logic [1:0] cmd_q;
	logic in_acc;

	assign in_acc = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || (out_valid && out_stall);

	always_comb begin
		cmd = '0;
		cmd.op = OP_NONE;
		if (in_acc) cmd.op = OP_LOAD;
		case (state_q)
			S_DISPATCH: begin
				case (cmd_q)
					CMD_PUT: cmd.op = stat.sgr_final ? OP_SGR_INIT : OP_CHAR;
					CMD_CLEAR: cmd.op = OP_CLEAR_INIT;
					default: ;
				endcase
			end
			S_CHK: if (stat.scroll_need) cmd.op = OP_SCROLL_INIT;
			S_BOOT: cmd.walk_step = 1'b1;
			S_WALK: cmd.walk_step = 1'b1;
			S_SGR: cmd.sgr_step = 1'b1;
			S_CAP: cmd.read_cap = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_BOOT;
			out_valid <= 1'b0;
			cmd_q <= '0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				S_BOOT: if (stat.walk_done) state_q <= S_IDLE;
				S_IDLE: if (in_acc) begin
					cmd_q <= in_command;
					state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					case (cmd_q)
						CMD_PUT: state_q <= stat.sgr_final ? S_SGR : S_CHK;
						CMD_CLEAR: state_q <= S_WALK;
						CMD_READ: state_q <= S_CAP;
						default: state_q <= S_OUT;
					endcase
				end
				S_CHK: state_q <= stat.scroll_need ? S_WALK : S_OUT;
				S_WALK: if (stat.walk_done) state_q <= S_OUT;
				S_SGR: if (stat.sgr_done) state_q <= S_OUT;
				S_CAP: state_q <= S_OUT;
				S_OUT: if (!out_valid || !out_stall) begin
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_acc) else $error("item accepted while busy");
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.walk_step && cmd.sgr_step)) else $error("walk and sgr overlap");
	a_out_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_OUT) else $error("stray result");
endmodule

### bench/ansi_text_console_core_tb.sv
// Testbench for ansi_text_console_core: drives put, read, clear and colour items,
// predicts each result with a local console model and checks it field by field.
// Depends on atc_pkg and the RTL under rtl.
module ansi_text_console_core_tb
	import atc_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 12000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;

	out_item_t expected_q[$];
	int errors = 0;
	int cycles = 0;

	logic [1:0] esc_mode;
	logic [7:0] sgr_params[PARAM_SLOTS];
	int sgr_slot;
	int cur_col;
	int cur_row;
	logic [7:0] cur_attr;
	logic [15:0] screen[CELL_COUNT];

	ansi_text_console_core dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	function automatic logic [2:0] colour_swap(input int c);
		logic [2:0] v;
		v = c[2:0];
		return {v[0], v[1], v[2]};
	endfunction

	function automatic void write_cell(input int idx, input logic [7:0] ch,
			input logic [7:0] attr);
		if (idx >= 0 && idx < CELL_COUNT)
			screen[idx] = {attr, ch};
	endfunction

	function automatic void apply_attributes();
		int p;
		for (int i = 0; i <= sgr_slot && i < PARAM_SLOTS; i++) begin
			p = sgr_params[i];
			if (p == 0)
				cur_attr = ATTR_RESET;
			else if (p == 1)
				cur_attr[3] = 1'b1;
			else if (p >= 30 && p <= 37)
				cur_attr[3:0] = {1'b0, colour_swap(p - 30)};
			else if (p >= 40 && p <= 47)
				cur_attr[7:4] = {1'b0, colour_swap(p - 40)};
			else if (p >= 90 && p <= 97)
				cur_attr[3:0] = {1'b1, colour_swap(p - 90)};
			else if (p >= 100 && p <= 107)
				cur_attr[7:4] = {1'b1, colour_swap(p - 100)};
		end
	endfunction

	function automatic void console_char(input logic [7:0] ch);
		int v;
		if (esc_mode == MODE_ESC) begin
			if (ch == CH_LBRACKET) begin
				esc_mode = MODE_CSI;
				foreach (sgr_params[i]) sgr_params[i] = '0;
				sgr_slot = 0;
			end else
				esc_mode = MODE_NORMAL;
			return;
		end
		if (esc_mode != MODE_NORMAL) begin
			if (ch >= "0" && ch <= "9") begin
				v = sgr_params[sgr_slot] * 10 + (ch - "0");
				sgr_params[sgr_slot] = (v > 255) ? 8'd255 : v[7:0];
			end else if (ch == CH_SEMI) begin
				if (sgr_slot < PARAM_SLOTS - 1)
					sgr_slot++;
			end else begin
				if (ch == CH_M)
					apply_attributes();
				esc_mode = MODE_NORMAL;
			end
			return;
		end
		if (ch == CH_ESC) begin
			esc_mode = MODE_ESC;
			return;
		end
		if (ch == CH_LF) begin
			cur_col = 0;
			cur_row++;
		end else if (ch == CH_CR)
			cur_col = 0;
		else if (ch == CH_TAB)
			cur_col = cur_col - (cur_col % TAB_STOP) + TAB_STOP;
		else if (ch == CH_BS) begin
			if (cur_col > 0)
				cur_col--;
			else if (cur_row > 0) begin
				cur_row--;
				cur_col = SCREEN_COLUMNS - 1;
			end
			write_cell(cur_row * SCREEN_COLUMNS + cur_col, CH_SPACE, cur_attr);
		end else if (ch != CH_NUL) begin
			write_cell(cur_row * SCREEN_COLUMNS + cur_col, ch, cur_attr);
			cur_col++;
		end
		if (cur_col >= SCREEN_COLUMNS) begin
			cur_col = 0;
			cur_row++;
		end
		if (cur_row >= SCREEN_ROWS) begin
			for (int i = 0; i < CELL_COUNT - SCREEN_COLUMNS; i++)
				screen[i] = screen[i + SCREEN_COLUMNS];
			for (int c = 0; c < SCREEN_COLUMNS; c++)
				write_cell((SCREEN_ROWS - 1) * SCREEN_COLUMNS + c, CH_SPACE, cur_attr);
			cur_row = SCREEN_ROWS - 1;
		end
	endfunction

	function automatic out_item_t console_step(input in_item_t it);
		out_item_t r;
		r = '0;
		case (cmd_t'(it.command))
			CMD_PUT: console_char(it.char_code);
			CMD_READ: if (it.cell_index < CELL_COUNT) begin
				r.read_char = screen[it.cell_index][7:0];
				r.read_attr = screen[it.cell_index][15:8];
			end
			CMD_CLEAR: begin
				for (int i = 0; i < CELL_COUNT; i++)
					screen[i] = {it.back, 4'h0, CH_SPACE};
				cur_col = 0;
				cur_row = 0;
			end
			default: cur_attr = {it.back, it.fore};
		endcase
		r.cursor_col = cur_col[6:0];
		r.cursor_row = cur_row[4:0];
		r.text_attr = cur_attr;
		return r;
	endfunction

	task automatic send_item(input in_item_t it);
		int idle;
		idle = $urandom_range(0, 7) * ($urandom_range(0, 3) != 0);
		if (idle != 0) begin
			in_valid <= 1'b0;
			in_item <= '0;
			repeat (idle) @(negedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		expected_q.push_back(console_step(it));
		@(negedge clk);
	endtask

	function automatic in_item_t make_item(input cmd_t c, input logic [7:0] ch = 0,
			input logic [10:0] idx = 0, input logic [3:0] f = 0, input logic [3:0] b = 0);
		in_item_t it;
		it.command = c;
		it.char_code = ch;
		it.cell_index = idx;
		it.fore = f;
		it.back = b;
		return it;
	endfunction

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(make_item(CMD_PUT, s[i]));
	endtask

	task automatic test_basic();
		send_item(make_item(CMD_READ, 8'hFF, 11'd0, 4'hF, 4'hF));
		send_text("Hi\t\010\015\n");
		send_item(make_item(CMD_PUT, 8'hFF));
		send_item(make_item(CMD_PUT, CH_NUL));
		send_item(make_item(CMD_PUT, 8'h01));
		send_item(make_item(CMD_READ, 0, 11'd1));
		send_item(make_item(CMD_READ, 0, 11'd2047));
		send_item(make_item(CMD_READ, 0, 11'd1999));
		send_item(make_item(CMD_COLOUR, 0, 0, 4'hF, 4'h0));
		send_item(make_item(CMD_COLOUR, 0, 0, 4'h0, 4'hF));
		send_item(make_item(CMD_CLEAR, 0, 0, 0, 4'hA));
		send_item(make_item(CMD_PUT, CH_BS));
	endtask

	task automatic test_escapes();
		send_text("\033[1;31;104;97m");
		send_text("\033[999;1;2;3;4;5m");
		send_text("\033x\033[42H\033[m\033[0;92;47;1m");
	endtask

	task automatic test_scroll();
		send_item(make_item(CMD_CLEAR, 0, 0, 0, 4'h3));
		for (int i = 0; i < SCREEN_ROWS; i++)
			send_item(make_item(CMD_PUT, CH_LF));
		for (int i = 0; i < 12; i++)
			send_item(make_item(CMD_PUT, CH_TAB));
		send_item(make_item(CMD_READ, 0, 11'(CELL_COUNT - 1)));
	endtask

	task automatic test_random(input int count);
		in_item_t it;
		int k;
		string digits;
		for (int n = 0; n < count; n++) begin
			it = $bits(in_item_t)'($urandom);
			k = $urandom_range(0, 99);
			if (k < 3)
				it.command = CMD_CLEAR;
			else if (k < 20)
				it.command = CMD_READ;
			else if (k < 25)
				it.command = CMD_COLOUR;
			else if (k < 40) begin
				digits = "\033[";
				repeat ($urandom_range(1, 5)) begin
					digits = {digits, $sformatf("%0d", $urandom_range(0, 3) == 0 ?
						$urandom_range(0, 400) : $urandom_range(0, 107))};
					if ($urandom_range(0, 3) != 0) digits = {digits, ";"};
				end
				digits = {digits, ($urandom_range(0, 5) == 0) ? "J" : "m"};
				send_text(digits);
				n += digits.len() - 1;
				continue;
			end else begin
				it.command = CMD_PUT;
				if ($urandom_range(0, 3) == 0)
					it.char_code = 8'($urandom_range(0, 31));
				else if ($urandom_range(0, 3) != 0)
					it.char_code = 8'($urandom_range(32, 126));
			end
			if (it.command == CMD_READ && $urandom_range(0, 9) != 0)
				it.cell_index = 11'($urandom_range(0, CELL_COUNT - 1));
			send_item(it);
		end
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (out_valid && !out_stall) begin
			if (expected_q.size() == 0)
				report("unexpected item", 1, 0);
			else begin
				want = expected_q.pop_front();
				if (out_item.cursor_col !== want.cursor_col)
					report("cursor_col", out_item.cursor_col, want.cursor_col);
				if (out_item.cursor_row !== want.cursor_row)
					report("cursor_row", out_item.cursor_row, want.cursor_row);
				if (out_item.read_char !== want.read_char)
					report("read_char", out_item.read_char, want.read_char);
				if (out_item.read_attr !== want.read_attr)
					report("read_attr", out_item.read_attr, want.read_attr);
				if (out_item.text_attr !== want.text_attr)
					report("text_attr", out_item.text_attr, want.text_attr);
			end
		end
	end

	always begin
		int wait_n;
		@(negedge clk);
		if (out_valid) begin
			wait_n = $urandom_range(0, 7);
			if (wait_n != 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(negedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
		end
	end

	initial begin
		esc_mode = MODE_NORMAL;
		foreach (sgr_params[i]) sgr_params[i] = '0;
		sgr_slot = 0;
		cur_col = 0;
		cur_row = 0;
		cur_attr = ATTR_RESET;
		foreach (screen[i]) screen[i] = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_basic();
		test_escapes();
		test_scroll();
		test_random(1000);
		in_valid <= 1'b0;
		in_item <= '0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (3000) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
